// ----- rtl/qs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_pkg
// Shared widths, defaults and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package qs_pkg;

	localparam int DATA_W           = 32;
	localparam int MAX_ELEMENTS_DEF = 64;

	typedef struct packed {
		logic in_ready;
		logic pop;
		logic pop_load;
		logic pivot;
		logic rd;
		logic cmp;
		logic swap;
		logic fin;
		logic push_r;
		logic emit_rd;
		logic emit_ld;
	} qs_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_last;
		logic n_lt2;
		logic sp_zero;
		logic k_eq_hi;
		logic less;
		logic place_eq_k;
		logic e_last;
		logic out_free;
	} qs_stat_t;

endpackage

// ----- rtl/qs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_in_if / qs_out_if
// Valid/ready channels for input elements and sorted results.
// ----------------------------------------------------------------------------
interface qs_in_if import qs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value;
	logic                     last_item;

	modport source (output valid, value, last_item, input ready);
	modport sink   (input valid, value, last_item, output ready);
endinterface

interface qs_out_if import qs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     end_of_set;
	logic                     overflowed;

	modport source (output valid, sorted_value, end_of_set, overflowed, input ready);
	modport sink   (input valid, sorted_value, end_of_set, overflowed, output ready);
endinterface

// ----- rtl/quicksort_sorter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_sorter
// Collects a set of signed values, sorts it by quicksort (Lomuto partition,
// explicit range stack) and streams it out in ascending order.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   beat
//  in_ch    in   value[31:0], last_item                    valid & ready
//  out_ch   out  sorted_value[31:0], end_of_set, overflowed valid & ready
//
//  Load: one input beat per cycle. Sort: read and compare states per
//  partition compare, a swap state per exchange; the single write port
//  of the element store sets this. Emit: a read and a load per result.
//  Reset clears count, stack pointer, overflow, output valid and state only.
//  An output stall holds the emit sequence; input is refused while busy.
// ----------------------------------------------------------------------------
module quicksort_sorter import qs_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	qs_in_if.sink    in_ch,
	qs_out_if.source out_ch
);

	qs_cmd_t  cmd;
	qs_stat_t stat;

	assign in_ch.ready = cmd.in_ready;

	qs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	qs_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_valid  (in_ch.valid),
		.in_value  (in_ch.value),
		.in_last   (in_ch.last_item),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_value (out_ch.sorted_value),
		.out_end   (out_ch.end_of_set),
		.out_ovf   (out_ch.overflowed)
	);

endmodule

// ----- rtl/qs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_ctrl
// Sequencer for load, Lomuto partition passes, range stack and emit.
// ----------------------------------------------------------------------------
module qs_ctrl import qs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  qs_stat_t stat,
	output qs_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_LOAD,
		S_POP,
		S_POPW,
		S_PIVOT,
		S_RD,
		S_CMP,
		S_SWAP,
		S_FIN,
		S_PUSHR,
		S_EMIT,
		S_EMITLD
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (stat.in_valid && stat.in_last) begin
						state_q <= stat.n_lt2 ? S_EMIT : S_POP;
					end
				end
				S_POP:    state_q <= stat.sp_zero ? S_EMIT : S_POPW;
				S_POPW:   state_q <= S_PIVOT;
				S_PIVOT:  state_q <= S_CMP;
				S_RD:     state_q <= S_CMP;
				S_CMP: begin
					if (stat.k_eq_hi) begin
						state_q <= S_FIN;
					end else if (stat.less && !stat.place_eq_k) begin
						state_q <= S_SWAP;
					end else begin
						state_q <= S_RD;
					end
				end
				S_SWAP:   state_q <= S_RD;
				S_FIN:    state_q <= S_PUSHR;
				S_PUSHR:  state_q <= S_POP;
				S_EMIT: begin
					if (stat.out_free) begin
						state_q <= S_EMITLD;
					end
				end
				S_EMITLD: state_q <= stat.e_last ? S_LOAD : S_EMIT;
				default:  state_q <= S_LOAD;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.in_ready = (state_q == S_LOAD);
		cmd.pop      = (state_q == S_POP) && !stat.sp_zero;
		cmd.pop_load = (state_q == S_POPW);
		cmd.pivot    = (state_q == S_PIVOT);
		cmd.rd       = (state_q == S_RD);
		cmd.cmp      = (state_q == S_CMP);
		cmd.swap     = (state_q == S_SWAP);
		cmd.fin      = (state_q == S_FIN);
		cmd.push_r   = (state_q == S_PUSHR);
		cmd.emit_rd  = (state_q == S_EMIT) && stat.out_free;
		cmd.emit_ld  = (state_q == S_EMITLD);
	end

endmodule

// ----- rtl/qs_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_datapath
// Element store, range stack, partition registers and output register.
// ----------------------------------------------------------------------------
module qs_datapath import qs_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  qs_cmd_t                  cmd,
	output qs_stat_t                 stat,
	input  logic                     in_valid,
	input  logic signed [DATA_W-1:0] in_value,
	input  logic                     in_last,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] out_value,
	output logic                     out_end,
	output logic                     out_ovf
);

	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	typedef struct packed {
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
	} range_t;

	logic signed [DATA_W-1:0] store_mem [MAX_ELEMENTS];
	range_t                   stack_mem [MAX_ELEMENTS];

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         sp_q;
	logic                     ovf_q;
	logic                     out_valid_q;

	logic [IDX_W-1:0]         lo_q, hi_q, k_q, place_q, e_q;
	logic signed [DATA_W-1:0] pivot_q, rd_a_q, rd_b_q;
	range_t                   stk_rd_q;

	logic                     accept, has_room;
	logic [CNT_W-1:0]         n_after;
	logic                     less, push_l_ok, push_r_ok, e_last;

	logic                     st_we;
	logic [IDX_W-1:0]         st_waddr;
	logic signed [DATA_W-1:0] st_wdata;
	logic                     sk_we;
	range_t                   sk_wdata;
	logic [IDX_W-1:0]         rd_a_addr;
	logic                     rd_a_en, rd_b_en;

	assign accept    = cmd.in_ready && in_valid;
	assign has_room  = count_q < CNT_W'(MAX_ELEMENTS);
	assign n_after   = count_q + CNT_W'(has_room);
	assign less      = rd_a_q < pivot_q;
	assign push_l_ok = {1'b0, place_q} > ({1'b0, lo_q} + (IDX_W + 1)'(1));
	assign push_r_ok = ({1'b0, place_q} + (IDX_W + 1)'(1)) < {1'b0, hi_q};
	assign e_last    = (CNT_W'(e_q) + CNT_W'(1)) == count_q;

	always_comb begin
		stat            = '0;
		stat.in_valid   = in_valid;
		stat.in_last    = in_last;
		stat.n_lt2      = n_after < CNT_W'(2);
		stat.sp_zero    = (sp_q == '0);
		stat.k_eq_hi    = (k_q == hi_q);
		stat.less       = less;
		stat.place_eq_k = (place_q == k_q);
		stat.e_last     = e_last;
		stat.out_free   = !out_valid_q || out_ready;
	end

	// store write port
	always_comb begin
		st_we    = 1'b0;
		st_waddr = count_q[IDX_W-1:0];
		st_wdata = in_value;
		if (accept) begin
			st_we = has_room;
		end else if (cmd.cmp && (k_q == hi_q)) begin
			st_we    = 1'b1;
			st_waddr = place_q;
			st_wdata = pivot_q;
		end else if (cmd.cmp && less && (place_q != k_q)) begin
			st_we    = 1'b1;
			st_waddr = place_q;
			st_wdata = rd_a_q;
		end else if (cmd.swap) begin
			st_we    = 1'b1;
			st_waddr = k_q;
			st_wdata = rd_b_q;
		end else if (cmd.fin) begin
			st_we    = 1'b1;
			st_waddr = hi_q;
			st_wdata = rd_b_q;
		end
	end

	// stack push
	always_comb begin
		sk_we    = 1'b0;
		sk_wdata = '0;
		if (accept) begin
			sk_we       = in_last && (n_after >= CNT_W'(2));
			sk_wdata.hi = IDX_W'(n_after - CNT_W'(1));
		end else if (cmd.fin) begin
			sk_we       = push_l_ok;
			sk_wdata.lo = lo_q;
			sk_wdata.hi = place_q - IDX_W'(1);
		end else if (cmd.push_r) begin
			sk_we       = push_r_ok;
			sk_wdata.lo = place_q + IDX_W'(1);
			sk_wdata.hi = hi_q;
		end
	end

	assign rd_a_en   = cmd.pop_load || cmd.pivot || cmd.rd || cmd.emit_rd;
	assign rd_b_en   = cmd.pivot || cmd.rd;
	assign rd_a_addr = cmd.pop_load ? stk_rd_q.hi : (cmd.emit_rd ? e_q : k_q);

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_waddr] <= st_wdata;
		end
		if (rd_a_en) begin
			rd_a_q <= store_mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rd_b_q <= store_mem[place_q];
		end
	end

	always_ff @(posedge clk) begin
		if (sk_we) begin
			stack_mem[sp_q[IDX_W-1:0]] <= sk_wdata;
		end
		if (cmd.pop) begin
			stk_rd_q <= stack_mem[IDX_W'(sp_q - CNT_W'(1))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sp_q        <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (has_room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (sk_we) begin
				sp_q <= sp_q + CNT_W'(1);
			end else if (cmd.pop) begin
				sp_q <= sp_q - CNT_W'(1);
			end
			if (cmd.emit_ld && e_last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (cmd.emit_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_last) begin
			e_q <= '0;
		end else if (cmd.emit_ld) begin
			e_q <= e_q + IDX_W'(1);
		end
		if (cmd.pop_load) begin
			lo_q    <= stk_rd_q.lo;
			hi_q    <= stk_rd_q.hi;
			k_q     <= stk_rd_q.lo;
			place_q <= stk_rd_q.lo;
		end else if (cmd.cmp && (k_q != hi_q)) begin
			if (less) begin
				place_q <= place_q + IDX_W'(1);
			end
			if (!(less && (place_q != k_q))) begin
				k_q <= k_q + IDX_W'(1);
			end
		end else if (cmd.swap) begin
			k_q <= k_q + IDX_W'(1);
		end
		if (cmd.pivot) begin
			pivot_q <= rd_a_q;
		end
		if (cmd.emit_ld) begin
			out_value <= rd_a_q;
			out_end   <= e_last;
			out_ovf   <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/qs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_checker
// Port-level checks on the sorter, bound to the top level.
// ----------------------------------------------------------------------------
module qs_checker import qs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_last,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] out_value,
	input logic              out_end,
	input logic              out_ovf
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)
			&& $stable(out_end) && $stable(out_ovf))
		else $error("result changed under stall");

	// closing beat ends the load, input refused next cycle
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input taken right after closing beat");

	// mid-set results only while the block is emitting
	a_no_load_mid_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_end |-> !in_ready)
		else $error("input ready while a set is still being emitted");

	// a taken mid-set result keeps the block busy
	a_emit_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_end |=> !in_ready)
		else $error("emit ended without a final result");

endmodule

bind quicksort_sorter qs_checker u_qs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_last   (in_ch.last_item),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_value (out_ch.sorted_value),
	.out_end   (out_ch.end_of_set),
	.out_ovf   (out_ch.overflowed)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quicksort_sorter. Sets of signed values are streamed
// in, a software copy of the Lomuto quicksort predicts the sorted beats, and
// every output beat is checked against the oldest prediction. Both channels
// idle at random, with a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
	import qs_pkg::*;

	localparam int CAPACITY    = MAX_ELEMENTS_DEF;
	localparam int IDLE_LIMIT  = 60000;
	localparam int TAIL_CYCLES = 40;
	localparam int RAND_ITEMS  = 20;

	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef logic signed [DATA_W-1:0] elem_t;

	typedef struct packed {
		elem_t sorted_value;
		logic  end_of_set;
		logic  overflowed;
	} sorted_beat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	qs_in_if  in_bus ();
	qs_out_if out_bus ();

	quicksort_sorter #(.MAX_ELEMENTS(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_bus),
		.out_ch (out_bus)
	);

	always #2 clk = ~clk;

	elem_t        held_vals [CAPACITY];
	int           held_count = 0;
	logic         lost_any   = 1'b0;
	sorted_beat_t pending_sorted [$];

	int err_count     = 0;
	bit src_idle_on   = 1'b1;
	bit sink_idle_on  = 1'b1;
	int sink_hold_req = 0;

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic elem_t rand_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return elem_t'($urandom);
		else if (r < 75)
			return elem_t'(int'($urandom_range(0, 8)) - 4);
		else if (r < 88)
			return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
		else if ($urandom_range(0, 1))
			return VAL_MAX - elem_t'($urandom_range(0, 3));
		else
			return VAL_MIN + elem_t'($urandom_range(0, 3));
	endfunction

	// Lomuto partition, last element as pivot, explicit range stack
	function automatic void sort_held(input int n);
		int    lo_q [$];
		int    hi_q [$];
		int    lo;
		int    hi;
		int    place;
		elem_t pivot;
		elem_t tmp;
		if (n < 2)
			return;
		lo_q.push_back(0);
		hi_q.push_back(n - 1);
		while (lo_q.size() > 0) begin
			lo = lo_q.pop_back();
			hi = hi_q.pop_back();
			if (lo >= hi)
				continue;
			pivot = held_vals[hi];
			place = lo;
			for (int k = lo; k < hi; k++) begin
				if (held_vals[k] < pivot) begin
					tmp              = held_vals[place];
					held_vals[place] = held_vals[k];
					held_vals[k]     = tmp;
					place++;
				end
			end
			tmp              = held_vals[place];
			held_vals[place] = held_vals[hi];
			held_vals[hi]    = tmp;
			if (place > lo + 1) begin
				lo_q.push_back(lo);
				hi_q.push_back(place - 1);
			end
			if (place + 1 < hi) begin
				lo_q.push_back(place + 1);
				hi_q.push_back(hi);
			end
		end
	endfunction

	function automatic void predict_beat(input elem_t v, input logic last);
		if (held_count < CAPACITY) begin
			held_vals[held_count] = v;
			held_count++;
		end else begin
			lost_any = 1'b1;
		end
		if (last) begin
			sort_held(held_count);
			for (int k = 0; k < held_count; k++)
				pending_sorted.push_back(sorted_beat_t'{held_vals[k],
					(k == held_count - 1), lost_any});
			held_count = 0;
			lost_any   = 1'b0;
		end
	endfunction

	task automatic send_value(input elem_t v, input logic last);
		int gap;
		gap = src_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_bus.valid     <= 1'b1;
		in_bus.value     <= v;
		in_bus.last_item <= last;
		do @(posedge clk); while (!in_bus.ready);
		predict_beat(v, last);
	endtask

	task automatic send_set(input elem_t vals [$]);
		foreach (vals[i])
			send_value(vals[i], (i == vals.size() - 1));
	endtask

	task automatic pause_input();
		in_bus.valid <= 1'b0;
		while (pending_sorted.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_directed();
		elem_t set_q [$];
		set_q = '{VAL_MIN};
		send_set(set_q);
		set_q = '{VAL_MAX};
		send_set(set_q);
		set_q = '{VAL_MAX, VAL_MIN};
		send_set(set_q);
		set_q = '{32'sd0, -32'sd1, 32'sd1, VAL_MAX, VAL_MIN, 32'sh55555555, 32'shAAAAAAAA};
		send_set(set_q);
		set_q = '{32'sd5, 32'sd5, -32'sd3, 32'sd5, -32'sd3};
		send_set(set_q);
		set_q = '{32'sd1, 32'sd2, 32'sd3, 32'sd4};
		send_set(set_q);
	endtask

	// full store in descending order: a slow partitioning case
	task automatic test_full_store();
		elem_t set_q [$];
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		for (int i = 0; i < CAPACITY; i++)
			set_q.push_back(VAL_MAX - elem_t'(i * 977));
		send_set(set_q);
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	// beats past capacity are dropped; the closing beat is one of them
	task automatic test_overflow();
		elem_t set_q [$];
		for (int i = 0; i < CAPACITY + 3; i++)
			set_q.push_back(rand_value());
		send_set(set_q);
	endtask

	task automatic test_backpressure();
		elem_t set_q [$];
		src_idle_on   = 1'b0;
		sink_hold_req = 500;
		for (int s = 0; s < 3; s++) begin
			set_q.delete();
			for (int i = 0; i < 3 + 2 * s; i++)
				set_q.push_back(rand_value());
			send_set(set_q);
		end
		src_idle_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		elem_t set_q [$];
		set_q = '{rand_value(), rand_value(), rand_value(), rand_value()};
		send_set(set_q);
		pause_input();
		set_q = '{rand_value()};
		send_set(set_q);
		pause_input();
	endtask

	task automatic test_random();
		elem_t set_q [$];
		int    sent;
		int    len;
		int    r;
		sent = 0;
		while (sent < RAND_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				len = $urandom_range(1, 8);
			else
				len = $urandom_range(9, 16);
			set_q.delete();
			for (int i = 0; i < len; i++)
				set_q.push_back(rand_value());
			src_idle_on  = ($urandom_range(0, 4) != 0);
			sink_idle_on = ($urandom_range(0, 4) != 0);
			send_set(set_q);
			sent += len;
		end
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	// result sink and checker
	initial begin
		int           stall_left;
		sorted_beat_t got;
		sorted_beat_t want;
		stall_left = 0;
		out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_bus.valid && out_bus.ready) begin
				got = sorted_beat_t'{out_bus.sorted_value, out_bus.end_of_set,
					out_bus.overflowed};
				if (pending_sorted.size() == 0) begin
					err_count++;
					$display("%0t: unexpected beat, expected none, got %0d/%b/%b",
						$time, got.sorted_value, got.end_of_set, got.overflowed);
				end else begin
					want = pending_sorted.pop_front();
					if (got.sorted_value !== want.sorted_value) begin
						err_count++;
						$display("%0t: sorted_value expected %0d, got %0d",
							$time, want.sorted_value, got.sorted_value);
					end
					if (got.end_of_set !== want.end_of_set) begin
						err_count++;
						$display("%0t: end_of_set expected %b, got %b",
							$time, want.end_of_set, got.end_of_set);
					end
					if (got.overflowed !== want.overflowed) begin
						err_count++;
						$display("%0t: overflowed expected %b, got %b",
							$time, want.overflowed, got.overflowed);
					end
				end
			end
			if (sink_hold_req > 0) begin
				stall_left    = sink_hold_req;
				sink_hold_req = 0;
			end
			if (stall_left > 0) begin
				out_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				out_bus.ready <= 1'b1;
				if (sink_idle_on)
					stall_left = pick_gap();
			end
		end
	end

	// watchdog: cycles with no beat on either channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("quicksort_sorter verification failed");
		$finish;
	end

	initial begin
		in_bus.valid     <= 1'b0;
		in_bus.value     <= '0;
		in_bus.last_item <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_store();
		test_overflow();
		test_backpressure();
		test_drain_pause();
		test_random();
		in_bus.valid <= 1'b0;
		while (pending_sorted.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("quicksort_sorter verification clean");
		else
			$display("quicksort_sorter verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/qs_pkg.sv
rtl/qs_if.sv
rtl/qs_ctrl.sv
rtl/qs_datapath.sv
rtl/quicksort_sorter.sv
rtl/qs_checker.sv
tb/tb_top.sv
